// ===== rtl/hht_pkg.sv =====
// Package for the hopscotch hash table block.
// Holds default sizes, the register reset value, result codes and sequencer states.
// No dependencies.
package hht_pkg;

    localparam int DEF_BUCKET_BITS  = 10;
    localparam int DEF_NEIGHBORHOOD = 8;
    localparam int DEF_ITEM_WIDTH   = 32;

    localparam int          WORD_W     = 32;
    localparam int          IDX_W      = 11;
    localparam int          POS_W      = 6;
    localparam int          GATHER_PER = 4;
    localparam logic [31:0] MASK_RESET = 32'd1023;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_NB_RD,
        S_NB_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DISP,
        S_BK_RD,
        S_BK_CHK,
        S_MV_RD,
        S_MV_WR,
        S_FAIL,
        S_PLACE_RD,
        S_PLACE_WR
    } state_t;

endpackage

// ===== rtl/hht_pext.sv =====
// Iterative parallel bit extract: gathers the masked bits of a word into a home index.
// Four mask bits per cycle, from bit 0 upwards. Uses hht_pkg.
module hht_pext
    import hht_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WORD_W-1:0]      mask,
    input  logic [WORD_W-1:0]      word,
    output logic                   done,
    output logic [BUCKET_BITS-1:0] index
);

    localparam int STEPS  = WORD_W / GATHER_PER;
    localparam int STEP_W = $clog2(STEPS);

    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [BUCKET_BITS-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0]      mask_reg, mask_next;
    logic [WORD_W-1:0]      word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        mask_reg <= mask_next;
        word_reg <= word_next;
    end

    always_comb
    begin
        logic [POS_W-1:0]       p;
        logic [BUCKET_BITS-1:0] x;
        logic [4:0]             b;
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        mask_next = mask_reg;
        word_next = word_reg;
        p = pos_reg;
        x = idx_reg;
        for (int k = 0; k < GATHER_PER; k++)
        begin
            b = 5'({step_reg, 2'(k)});
            if (mask_reg[b])
            begin
                if (word_reg[b])
                    x = x | (BUCKET_BITS'(1) << p);
                p = p + POS_W'(1);
            end
        end
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            pos_next  = '0;
            idx_next  = '0;
            mask_next = mask;
            word_next = word;
        end
        else if (run_reg)
        begin
            pos_next  = p;
            idx_next  = x;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign index = idx_reg;

endmodule

// ===== rtl/hopscotch_hash_table.sv =====
// Top level of the hopscotch hash table: sequencer, bucket store and hop bitmaps.
// Uses hht_pkg and the bit extract unit hht_pext.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  request  | start, busy (start & !busy)| req_type, item_value
//  result   | done (one-cycle strobe)    | status, bucket_index
//  config   | hash_mask_we               | hash_mask_wdata
//
// After reset the block clears the store and hop bitmaps, busy until all TABLE_SLOTS slots
// (1031 by default) are cleared. Zero items answer the next cycle. Otherwise the home
// bucket is extracted first, then slots are read and checked one at a time, as each memory
// has a single port; a displacing insert also moves items. Results cannot be stalled.
module hopscotch_hash_table
    import hht_pkg::*;
#(
    parameter int BUCKET_BITS  = DEF_BUCKET_BITS,
    parameter int NEIGHBORHOOD = DEF_NEIGHBORHOOD,
    parameter int ITEM_WIDTH   = DEF_ITEM_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [WORD_W-1:0] item_value,
    input  logic              hash_mask_we,
    input  logic [WORD_W-1:0] hash_mask_wdata,
    output logic              done,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  bucket_index
);

    localparam int NUM_HOMES   = 1 << BUCKET_BITS;
    localparam int TABLE_SLOTS = NUM_HOMES + NEIGHBORHOOD - 1;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int PW          = $clog2(TABLE_SLOTS + 1);
    localparam int OFS_W       = $clog2(NEIGHBORHOOD);
    localparam int IW          = ITEM_WIDTH < WORD_W ? ITEM_WIDTH : WORD_W;
    localparam logic [WORD_W-1:0] IMASK =
        ITEM_WIDTH >= WORD_W ? '1 : ((WORD_W'(1) << IW) - WORD_W'(1));

    state_t state_reg, state_next;
    logic [WORD_W-1:0]      hash_mask_reg;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [PW-1:0]          where_reg, where_next;
    logic [PW-1:0]          clr_reg, clr_next;
    logic [IW-1:0]          item_reg, item_next;
    logic                   type_reg, type_next;
    logic [BUCKET_BITS-1:0] key_reg, key_next;
    logic [OFS_W-1:0]       i_reg, i_next;
    logic [OFS_W-1:0]       back_reg, back_next;
    logic [PW-1:0]          probe_reg, probe_next;
    logic [PW-1:0]          src_reg, src_next;

    logic [IW-1:0]           store_mem [TABLE_SLOTS];
    logic [NEIGHBORHOOD-1:0] hop_mem [NUM_HOMES];
    logic                    st_we, hop_we;
    logic [SLOT_W-1:0]       st_addr;
    logic [BUCKET_BITS-1:0]  hop_addr;
    logic [IW-1:0]           st_wdata, st_rdata_reg;
    logic [NEIGHBORHOOD-1:0] hop_wdata, hop_rdata_reg;

    logic                   px_start, px_done;
    logic [BUCKET_BITS-1:0] px_index;
    logic [WORD_W-1:0]      item_in;
    logic [PW+IDX_W-1:0]    where_wide;

    assign item_in = item_value & IMASK;

    hht_pext #(
        .BUCKET_BITS(BUCKET_BITS)
    ) u_pext (
        .clk   (clk),
        .rst_n (rst_n),
        .start (px_start),
        .mask  (hash_mask_reg),
        .word  (item_in),
        .done  (px_done),
        .index (px_index)
    );

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_addr] <= st_wdata;
        st_rdata_reg <= store_mem[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hop_we)
            hop_mem[hop_addr] <= hop_wdata;
        hop_rdata_reg <= hop_mem[hop_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hash_mask_reg <= MASK_RESET;
            done_reg      <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            clr_reg   <= clr_next;
            if (hash_mask_we)
                hash_mask_reg <= hash_mask_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        where_reg  <= where_next;
        item_reg   <= item_next;
        type_reg   <= type_next;
        key_reg    <= key_next;
        i_reg      <= i_next;
        back_reg   <= back_next;
        probe_reg  <= probe_next;
        src_reg    <= src_next;
    end

    always_comb
    begin
        logic [PW-1:0]           nb_slot;
        logic [PW-1:0]           base;
        logic [PW-1:0]           span;
        logic [NEIGHBORHOOD-1:0] bm;
        logic [NEIGHBORHOOD-1:0] cand;
        logic [OFS_W-1:0]        tsel;
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        where_next  = where_reg;
        clr_next    = clr_reg;
        item_next   = item_reg;
        type_next   = type_reg;
        key_next    = key_reg;
        i_next      = i_reg;
        back_next   = back_reg;
        probe_next  = probe_reg;
        src_next    = src_reg;
        px_start    = 1'b0;
        st_we       = 1'b0;
        st_addr     = probe_reg[SLOT_W-1:0];
        st_wdata    = item_reg;
        hop_we      = 1'b0;
        hop_addr    = key_reg;
        hop_wdata   = hop_rdata_reg;

        nb_slot = PW'(key_reg) + PW'(i_reg);
        base    = probe_reg - PW'(back_reg);
        span    = probe_reg - PW'(key_reg);
        bm      = (base < PW'(NUM_HOMES)) ? hop_rdata_reg : '0;
        cand    = bm & ((NEIGHBORHOOD'(1) << back_reg) - NEIGHBORHOOD'(1));
        tsel    = '0;
        for (int t = NEIGHBORHOOD - 1; t >= 0; t--)
        begin
            if (cand[t])
                tsel = OFS_W'(t);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                st_we     = 1'b1;
                st_addr   = clr_reg[SLOT_W-1:0];
                st_wdata  = '0;
                hop_we    = clr_reg < PW'(NUM_HOMES);
                hop_addr  = clr_reg[BUCKET_BITS-1:0];
                hop_wdata = '0;
                clr_next  = clr_reg + PW'(1);
                if (clr_reg == PW'(TABLE_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item_in[IW-1:0];
                    type_next = req_type;
                    if (item_in == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ZERO;
                        where_next  = '0;
                    end
                    else
                    begin
                        px_start   = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (px_done)
                begin
                    key_next   = px_index;
                    i_next     = '0;
                    state_next = S_NB_RD;
                end
            end
            S_NB_RD:
            begin
                st_addr    = nb_slot[SLOT_W-1:0];
                state_next = S_NB_CHK;
            end
            S_NB_CHK:
            begin
                if (type_reg)
                begin
                    if (st_rdata_reg == item_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        where_next  = nb_slot;
                        state_next  = S_IDLE;
                    end
                    else if (i_reg == OFS_W'(NEIGHBORHOOD - 1))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        where_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + OFS_W'(1);
                        state_next = S_NB_RD;
                    end
                end
                else
                begin
                    if (st_rdata_reg == '0)
                    begin
                        probe_next = nb_slot;
                        state_next = S_PLACE_RD;
                    end
                    else if (i_reg == OFS_W'(NEIGHBORHOOD - 1))
                    begin
                        probe_next = PW'(key_reg) + PW'(NEIGHBORHOOD);
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + OFS_W'(1);
                        state_next = S_NB_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (probe_reg >= PW'(TABLE_SLOTS))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    where_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (st_rdata_reg == '0)
                    state_next = S_DISP;
                else
                begin
                    probe_next = probe_reg + PW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_DISP:
            begin
                if (span >= PW'(NEIGHBORHOOD))
                begin
                    back_next  = OFS_W'(1);
                    state_next = S_BK_RD;
                end
                else
                    state_next = S_PLACE_RD;
            end
            S_BK_RD:
            begin
                hop_addr   = base[BUCKET_BITS-1:0];
                state_next = S_BK_CHK;
            end
            S_BK_CHK:
            begin
                if (cand != '0)
                begin
                    hop_we     = 1'b1;
                    hop_addr   = base[BUCKET_BITS-1:0];
                    hop_wdata  = (bm & ~(NEIGHBORHOOD'(1) << tsel))
                                 | (NEIGHBORHOOD'(1) << back_reg);
                    src_next   = base + PW'(tsel);
                    state_next = S_MV_RD;
                end
                else if (back_reg == OFS_W'(NEIGHBORHOOD - 1))
                    state_next = S_FAIL;
                else
                begin
                    back_next  = back_reg + OFS_W'(1);
                    state_next = S_BK_RD;
                end
            end
            S_MV_RD:
            begin
                st_addr    = src_reg[SLOT_W-1:0];
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                st_we      = 1'b1;
                st_wdata   = st_rdata_reg;
                probe_next = src_reg;
                state_next = S_DISP;
            end
            S_FAIL:
            begin
                st_we       = 1'b1;
                st_wdata    = '0;
                done_next   = 1'b1;
                status_next = ST_FULL;
                where_next  = '0;
                state_next  = S_IDLE;
            end
            S_PLACE_RD:
            begin
                state_next = S_PLACE_WR;
            end
            S_PLACE_WR:
            begin
                st_we       = 1'b1;
                hop_we      = 1'b1;
                hop_wdata   = hop_rdata_reg | (NEIGHBORHOOD'(1) << span[OFS_W-1:0]);
                done_next   = 1'b1;
                status_next = ST_OK;
                where_next  = probe_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign where_wide   = {{IDX_W{1'b0}}, where_reg};
    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign bucket_index = where_wide[IDX_W-1:0];

endmodule

// ===== tb/tb_hopscotch_hash_table.sv =====
// Testbench for hopscotch_hash_table: random and directed inserts and lookups under several
// hash masks, checked against an in-bench hopscotch table predictor.
// Depends on hht_pkg and the hopscotch_hash_table RTL.
module tb_hopscotch_hash_table;
    import hht_pkg::*;

    localparam int  NB         = 1 << DEF_BUCKET_BITS;
    localparam int  NH         = DEF_NEIGHBORHOOD;
    localparam int  SLOTS      = NB + NH - 1;
    localparam int  CYCLE_CAP  = 8000000;
    localparam bit  REQ_INSERT = 1'b0;
    localparam bit  REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        status_t          code;
        logic [IDX_W-1:0] slot;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              req_type = 1'b0;
    logic [WORD_W-1:0] item_value = '0;
    logic              hash_mask_we = 1'b0;
    logic [WORD_W-1:0] hash_mask_wdata = '0;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [IDX_W-1:0]  bucket_index;

    request_t    pending_items[$];
    answer_t     expected_answers[$];
    logic [31:0] inserted_values[$];
    logic [31:0] table_words[SLOTS];
    logic [NH-1:0] hop_maps[NB];
    logic [31:0] model_mask;
    int          idle_pct;
    int          mismatches;
    int          cycles;
    int          accepted;
    int          status_seen[4];

    hopscotch_hash_table i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .item_value     (item_value),
        .hash_mask_we   (hash_mask_we),
        .hash_mask_wdata(hash_mask_wdata),
        .done           (done),
        .status         (status),
        .bucket_index   (bucket_index)
    );

    always #6 clk = ~clk;

    function automatic int home_bucket(logic [31:0] v);
        int idx;
        int pos;
        idx = 0;
        pos = 0;
        for (int b = 0; b < 32; b++)
        begin
            if (model_mask[b])
            begin
                if (v[b])
                    idx |= 1 << pos;
                pos++;
            end
        end
        return idx & (NB - 1);
    endfunction

    function automatic answer_t predict_insert(logic [31:0] v);
        answer_t     a;
        int          key;
        int          probe;
        int          base;
        logic [NH-1:0] bm;
        bit          moved;
        a.code = ST_FULL;
        a.slot = '0;
        key = home_bucket(v);
        for (int i = 0; i < NH; i++)
        begin
            if (table_words[key + i] == 0)
            begin
                table_words[key + i] = v;
                hop_maps[key][i] = 1'b1;
                a.code = ST_OK;
                a.slot = IDX_W'(key + i);
                return a;
            end
        end
        probe = key + NH;
        while (probe < SLOTS && table_words[probe] != 0)
            probe++;
        if (probe >= SLOTS)
            return a;
        while (probe - key >= NH)
        begin
            moved = 1'b0;
            for (int back = 1; back < NH && !moved; back++)
            begin
                base = probe - back;
                bm = (base < NB) ? hop_maps[base] : '0;
                for (int t = 0; t < back && !moved; t++)
                begin
                    if (bm[t])
                    begin
                        table_words[probe] = table_words[base + t];
                        bm[t] = 1'b0;
                        bm[back] = 1'b1;
                        hop_maps[base] = bm;
                        probe = base + t;
                        moved = 1'b1;
                    end
                end
            end
            if (!moved)
            begin
                table_words[probe] = '0;
                return a;
            end
        end
        table_words[probe] = v;
        hop_maps[key][probe - key] = 1'b1;
        a.code = ST_OK;
        a.slot = IDX_W'(probe);
        return a;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        int      key;
        a.code = ST_MISS;
        a.slot = '0;
        if (r.value == 0)
            a.code = ST_ZERO;
        else if (r.kind == REQ_INSERT)
            a = predict_insert(r.value);
        else
        begin
            key = home_bucket(r.value);
            for (int i = 0; i < NH; i++)
            begin
                if (a.code != ST_OK && table_words[key + i] == r.value)
                begin
                    a.code = ST_OK;
                    a.slot = IDX_W'(key + i);
                end
            end
        end
        return a;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_answers.push_back(predict_answer('{req_type, item_value}));
                accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start      <= 1'b1;
                    req_type   <= pending_items[0].kind;
                    item_value <= pending_items[0].value;
                    if (pending_items[0].kind == REQ_INSERT && pending_items[0].value != 0)
                        inserted_values.push_back(pending_items[0].value);
                    void'(pending_items.pop_front());
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t e;
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("hopscotch_hash_table test failed");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d index %0d", status, bucket_index);
            end
            else
            begin
                e = expected_answers.pop_front();
                status_seen[e.code]++;
                if (status !== e.code || bucket_index !== e.slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d index %0d, got %0d %0d",
                                 e.code, e.slot, status, bucket_index);
                end
            end
        end
    end

    task automatic add_item(logic kind, logic [31:0] v);
        pending_items.push_back('{kind, v});
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_answers.size() > 0 || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(logic [31:0] m);
        @(posedge clk);
        hash_mask_we    <= 1'b1;
        hash_mask_wdata <= m;
        @(posedge clk);
        hash_mask_we    <= 1'b0;
        model_mask = m;
    endtask

    task automatic add_random(int n);
        logic [31:0] v;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                v = '0;
            else if (pick < 40 && inserted_values.size() > 0)
                v = inserted_values[$urandom_range(inserted_values.size() - 1)];
            else if (pick < 55)
                v = $urandom_range(255) + 1;
            else
                v = $urandom;
            add_item(1'($urandom_range(1)), v);
        end
    endtask

    initial
    begin
        logic [31:0] masks[7];
        masks = '{32'h0000000F, 32'hFFFFFFFF, 32'hF0F0F000, 32'h00000000,
                  32'hFFC00000, 32'h00000007, 32'hAAAAAAAA};
        model_mask = MASK_RESET;
        idle_pct = 16;
        for (int i = 0; i < SLOTS; i++)
            table_words[i] = '0;
        for (int i = 0; i < NB; i++)
            hop_maps[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        add_item(REQ_INSERT, 32'h0);
        add_item(REQ_LOOKUP, 32'h0);
        add_item(REQ_INSERT, 32'hFFFFFFFF);
        add_item(REQ_LOOKUP, 32'hFFFFFFFF);
        add_item(REQ_INSERT, 32'hFFFFFFFF);
        add_item(REQ_LOOKUP, 32'h00000001);
        add_item(REQ_INSERT, 32'h00000001);
        add_item(REQ_LOOKUP, 32'h00000001);
        for (int i = 0; i < 10; i++)
            add_item(REQ_INSERT, 32'h000003FF | (i << 12));
        add_item(REQ_LOOKUP, 32'h000093FF);
        add_item(REQ_LOOKUP, 32'h000003FE);
        wait_drained();

        write_mask(32'h0);
        for (int i = 1; i <= 10; i++)
            add_item(REQ_INSERT, i * 32'h01010101);
        add_item(REQ_LOOKUP, 32'h05050505);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            if (p == 2)
                idle_pct = 56;
            if (p == 5)
                idle_pct = 0;
            write_mask(masks[p]);
            add_random(147);
            wait_drained();
        end

        $display("%0d items accepted over 9 mask settings, sender idle 16/56/0 percent",
                 accepted);
        $display("results: %0d ok, %0d not found, %0d no space, %0d zero rejected",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("hopscotch_hash_table test passed");
        else
            $display("hopscotch_hash_table test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hht_pkg.sv
rtl/hht_pext.sv
rtl/hopscotch_hash_table.sv
tb/tb_hopscotch_hash_table.sv
